// File: hw/rtl/dsds_pkg.sv
// ----------------------------------------------------------------------------
// dsds_pkg: shared definitions for the sad disparity search unit
// lane count, field widths, cost limits and the stage record types
// ----------------------------------------------------------------------------
package dsds_pkg;

  localparam int LANES       = 8;
  localparam int BYTE_W      = 8;
  localparam int FIELD_BYTES = 8;
  localparam int FIELD_W     = FIELD_BYTES * BYTE_W;
  localparam int SAD_MAX     = LANES * ((1 << BYTE_W) - 1);
  localparam int SAD_W       = $clog2(SAD_MAX + 1);
  localparam int COST_W      = 16;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;

  localparam logic [COST_W-1:0] COST_MAX    = '1;
  localparam logic [CNT_W-1:0]  INDEX_LIMIT = CNT_W'(1 << IDX_W);
  localparam logic [CNT_W-1:0]  INDEX_SAT   = '1;
  localparam logic [CNT_W-1:0]  MAXD_RESET  = CNT_W'(64);

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic candidate_done;
    logic search_done;
    logic pixel_enabled;
  } flags_t;

  typedef struct packed {
    logic [SAD_W-1:0] sad;
    flags_t           flags;
  } slice_t;

endpackage

// File: hw/rtl/dsds_in_if.sv
// ----------------------------------------------------------------------------
// dsds_in_if: descriptor slice channel
// one transaction carries one slice pair plus its framing bits
// ----------------------------------------------------------------------------
interface dsds_in_if;
  logic                         valid;
  logic                         ready;
  logic [dsds_pkg::FIELD_W-1:0] ref_bytes;
  logic [dsds_pkg::FIELD_W-1:0] cand_bytes;
  logic                         candidate_done;
  logic                         search_done;
  logic                         pixel_enabled;

  modport source (
    output valid, ref_bytes, cand_bytes, candidate_done, search_done, pixel_enabled,
    input  ready
  );
  modport sink (
    input  valid, ref_bytes, cand_bytes, candidate_done, search_done, pixel_enabled,
    output ready
  );
endinterface

// File: hw/rtl/dsds_out_if.sv
// ----------------------------------------------------------------------------
// dsds_out_if: disparity result channel
// one transaction carries the winning disparity and its cost
// ----------------------------------------------------------------------------
interface dsds_out_if;
  logic                        valid;
  logic                        ready;
  logic [dsds_pkg::IDX_W-1:0]  disparity;
  logic [dsds_pkg::COST_W-1:0] match_cost;

  modport source (output valid, disparity, match_cost, input ready);
  modport sink (input valid, disparity, match_cost, output ready);
endinterface

// File: hw/rtl/dsds_lane.sv
// ----------------------------------------------------------------------------
// dsds_lane: one byte lane
// absolute difference of a reference byte and a candidate byte
// ----------------------------------------------------------------------------
module dsds_lane (
  input  dsds_pkg::byte_t ref_byte,
  input  dsds_pkg::byte_t cand_byte,
  output dsds_pkg::byte_t abs_diff
);

  assign abs_diff = (ref_byte > cand_byte) ? (ref_byte - cand_byte)
                                           : (cand_byte - ref_byte);

endmodule

// File: hw/rtl/dsds_merge.sv
// ----------------------------------------------------------------------------
// dsds_merge: lane merge
// adds the per-lane absolute differences into the slice sad
// ----------------------------------------------------------------------------
module dsds_merge (
  input  dsds_pkg::byte_t [dsds_pkg::LANES-1:0] lane_diff,
  output logic [dsds_pkg::SAD_W-1:0]            slice_sad
);

  always_comb begin
    slice_sad = '0;
    for (int i = 0; i < dsds_pkg::LANES; i++) begin
      slice_sad = slice_sad + dsds_pkg::SAD_W'(lane_diff[i]);
    end
  end

endmodule

// File: hw/rtl/dsds_search.sv
// ----------------------------------------------------------------------------
// dsds_search: winner-take-all tracker
// accumulates candidate cost, keeps the best candidate, drives the result
// ----------------------------------------------------------------------------
module dsds_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dsds_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic                         slice_valid,
  input  dsds_pkg::slice_t             slice,
  output logic                         slice_take,
  dsds_out_if.source                   out_chan
);

  logic [dsds_pkg::CNT_W-1:0]  max_disp_r;
  logic [dsds_pkg::COST_W-1:0] running_r, running_nxt;
  logic [dsds_pkg::COST_W-1:0] best_sum_r, best_sum_nxt;
  logic [dsds_pkg::IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [dsds_pkg::CNT_W-1:0]  cand_idx_r, cand_idx_nxt;
  logic                        exact_r, exact_nxt;
  logic                        out_valid_r;
  logic [dsds_pkg::IDX_W-1:0]  out_disp_r;
  logic [dsds_pkg::COST_W-1:0] out_cost_r;

  logic [dsds_pkg::CNT_W-1:0]  limit;
  logic                        active;
  logic                        close_cand;
  logic [dsds_pkg::COST_W:0]   sum_wide;
  logic [dsds_pkg::COST_W-1:0] cand_cost;

  // an item without a result never waits on the output slot
  assign slice_take = slice_valid &&
                      (!slice.flags.search_done || !out_valid_r || out_chan.ready);

  always_comb begin
    limit      = (max_disp_r > dsds_pkg::INDEX_LIMIT) ? dsds_pkg::INDEX_LIMIT : max_disp_r;
    active     = (cand_idx_r < limit) && !exact_r;
    close_cand = slice.flags.candidate_done || slice.flags.search_done;
    sum_wide   = {1'b0, running_r} + (dsds_pkg::COST_W + 1)'(slice.sad);
    cand_cost  = sum_wide[dsds_pkg::COST_W] ? dsds_pkg::COST_MAX
                                           : sum_wide[dsds_pkg::COST_W-1:0];

    running_nxt  = active ? cand_cost : running_r;
    best_sum_nxt = best_sum_r;
    best_idx_nxt = best_idx_r;
    cand_idx_nxt = cand_idx_r;
    exact_nxt    = exact_r;

    if (close_cand) begin
      if (active && (cand_cost < best_sum_r)) begin
        best_sum_nxt = cand_cost;
        best_idx_nxt = cand_idx_r[dsds_pkg::IDX_W-1:0];
        exact_nxt    = (cand_cost == '0);
      end
      running_nxt = '0;
      if (cand_idx_r != dsds_pkg::INDEX_SAT) begin
        cand_idx_nxt = cand_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_disp_r  <= dsds_pkg::MAXD_RESET;
      running_r   <= '0;
      best_sum_r  <= dsds_pkg::COST_MAX;
      best_idx_r  <= '0;
      cand_idx_r  <= '0;
      exact_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_disp_r <= cfg_wdata;
      end
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (slice_take) begin
        if (slice.flags.search_done) begin
          out_valid_r <= 1'b1;
          running_r   <= '0;
          best_sum_r  <= dsds_pkg::COST_MAX;
          best_idx_r  <= '0;
          cand_idx_r  <= '0;
          exact_r     <= 1'b0;
        end else begin
          running_r  <= running_nxt;
          best_sum_r <= best_sum_nxt;
          best_idx_r <= best_idx_nxt;
          cand_idx_r <= cand_idx_nxt;
          exact_r    <= exact_nxt;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (slice_take && slice.flags.search_done) begin
      out_disp_r <= slice.flags.pixel_enabled ? best_idx_nxt : '0;
      out_cost_r <= slice.flags.pixel_enabled ? best_sum_nxt : '0;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.disparity  = out_disp_r;
  assign out_chan.match_cost = out_cost_r;

endmodule

// File: hw/rtl/descriptor_sad_disparity_search_unit.sv
// ----------------------------------------------------------------------------
// descriptor_sad_disparity_search_unit: stereo sad winner-take-all search
// the search-done slice passes the slice stage and result registers
// throughput: one slice transaction per cycle from the tracker's accumulate
//   and compare loop; a search-done slice stalls while the result is unread
// reset: synchronous active-low; clears pipeline valids, per-pixel search
//   state, and loads the disparity limit with 64
// ----------------------------------------------------------------------------
module descriptor_sad_disparity_search_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [dsds_pkg::CNT_W-1:0] cfg_wdata,
  dsds_in_if.sink                    in_chan,
  dsds_out_if.source                 out_chan
);

  // stage 1: byte lanes and merge, registered into the slice stage
  dsds_pkg::byte_t [dsds_pkg::LANES-1:0] lane_diff;
  logic [dsds_pkg::SAD_W-1:0]            slice_sad;

  // stage 2: tracker consumes the registered slice
  logic             s1_valid_r;
  dsds_pkg::slice_t s1_r;
  logic             s1_take;
  logic             in_fire;

  // lanes beyond the bytes of a field compare zero with zero
  for (genvar i = 0; i < dsds_pkg::LANES; i++) begin : g_lane
    dsds_pkg::byte_t ref_b, cand_b;
    if (i < dsds_pkg::FIELD_BYTES) begin : g_live
      assign ref_b  = in_chan.ref_bytes[i*dsds_pkg::BYTE_W +: dsds_pkg::BYTE_W];
      assign cand_b = in_chan.cand_bytes[i*dsds_pkg::BYTE_W +: dsds_pkg::BYTE_W];
    end else begin : g_idle
      assign ref_b  = '0;
      assign cand_b = '0;
    end
    dsds_lane u_lane (
      .ref_byte  (ref_b),
      .cand_byte (cand_b),
      .abs_diff  (lane_diff[i])
    );
  end

  dsds_merge u_merge (
    .lane_diff (lane_diff),
    .slice_sad (slice_sad)
  );

  // slice stage moves whenever it is empty or the tracker takes it
  assign in_chan.ready = !s1_valid_r || s1_take;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  // slice payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.sad                  <= slice_sad;
      s1_r.flags.candidate_done <= in_chan.candidate_done;
      s1_r.flags.search_done    <= in_chan.search_done;
      s1_r.flags.pixel_enabled  <= in_chan.pixel_enabled;
    end
  end

  // winner-take-all tracker with the result register
  dsds_search u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .slice_valid (s1_valid_r),
    .slice       (s1_r),
    .slice_take  (s1_take),
    .out_chan    (out_chan)
  );

endmodule
